@@ hw/rtl/d54b_pkg.sv @@
// Shared types and constants for the DMX512 to D54 frame bridge.
package d54b_pkg;

    localparam int STORE_DEPTH = 512;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 10;

    localparam logic [9:0] CHANNEL_COUNT_RST   = 10'd384;
    localparam logic [7:0] SYNC_TICKS_RST      = 8'd1;
    localparam logic [7:0] BYTE_TICKS_RST      = 8'd3;
    localparam logic [7:0] EOF_TICKS_RST       = 8'd10;
    localparam logic [7:0] START_TICKS_RST     = 8'd10;

    typedef enum logic [CFG_AW-1:0] {
        CFG_CHANNEL_COUNT   = 3'd0,
        CFG_SYNC_TICKS      = 3'd1,
        CFG_BYTE_TICKS      = 3'd2,
        CFG_EOF_TICKS       = 3'd3,
        CFG_START_TICKS     = 3'd4,
        CFG_SYNC_ACTIVE_LOW = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        REQ_BYTE    = 2'd0,
        REQ_TIMEOUT = 2'd1,
        REQ_TICK    = 2'd2
    } req_type_t;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_SYNC  = 2'd1,
        PH_BYTE  = 2'd2,
        PH_EOF   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        DATA_KEEP = 2'd0,
        DATA_ZERO = 2'd1,
        DATA_LOAD = 2'd2
    } data_op_t;

    // Item in flight between acceptance and the output register
    typedef struct packed {
        data_op_t   data_op;
        logic       sync;
        logic [7:0] hold;
        logic       updated;
        logic       ok;
    } stage_t;

endpackage

@@ hw/rtl/dmx_to_d54_frame_bridge_unit.sv @@
// DMX512 to D54 frame bridge: channel store, frame sequencer and result stage.
// An accepted item passes through stage 1 and then the output register before it shows on m_tvalid.
// Throughput: one item per cycle while m_tready keeps the output moving; the channel store (one write
// port, one read port with a registered read) takes at most one access per item.
// Reset: rst_n clears control state at once, then a clearing pass over all
// STORE_DEPTH (512) entries zeroes the channel store; s_tready stays low until it ends.
module dmx_to_d54_frame_bridge_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [d54b_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [d54b_pkg::CFG_DW-1:0]   cfg_wdata,
    // input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
    input  logic [2:0]                    s_tuser,   // [1:0] req_type, [2] framing_error
    // result items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata    // [7:0] data_out, [8] sync_asserted,
                                                     // [9] sync_pin, [17:10] hold_ticks,
                                                     // [18] hold_updated, [19] dmx_ok,
                                                     // [23:20] zero
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [9:0] channel_count_reg;
    logic [7:0] sync_ticks_reg;
    logic [7:0] byte_ticks_reg;
    logic [7:0] eof_ticks_reg;
    logic [7:0] start_ticks_reg;
    logic       sync_active_low_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg   <= d54b_pkg::CHANNEL_COUNT_RST;
            sync_ticks_reg      <= d54b_pkg::SYNC_TICKS_RST;
            byte_ticks_reg      <= d54b_pkg::BYTE_TICKS_RST;
            eof_ticks_reg       <= d54b_pkg::EOF_TICKS_RST;
            start_ticks_reg     <= d54b_pkg::START_TICKS_RST;
            sync_active_low_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                d54b_pkg::CFG_CHANNEL_COUNT:   channel_count_reg   <= cfg_wdata[9:0];
                d54b_pkg::CFG_SYNC_TICKS:      sync_ticks_reg      <= cfg_wdata[7:0];
                d54b_pkg::CFG_BYTE_TICKS:      byte_ticks_reg      <= cfg_wdata[7:0];
                d54b_pkg::CFG_EOF_TICKS:       eof_ticks_reg       <= cfg_wdata[7:0];
                d54b_pkg::CFG_START_TICKS:     start_ticks_reg     <= cfg_wdata[7:0];
                d54b_pkg::CFG_SYNC_ACTIVE_LOW: sync_active_low_reg <= cfg_wdata[0];
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake and pipeline control
    // ------------------------------------------------------------------
    logic                             clearing_reg;
    logic [d54b_pkg::STORE_AW-1:0]    clr_cnt_reg;
    logic                             s1_valid_reg;
    d54b_pkg::stage_t                 s1_reg;
    logic                             m_tvalid_reg;

    logic accept;
    logic s1_adv;      // stage 1 may move into the output register
    logic s1_move;

    assign s1_adv   = !m_tvalid_reg || m_tready;
    assign s1_move  = s1_valid_reg && s1_adv;
    assign s_tready = !clearing_reg && (!s1_valid_reg || s1_adv);
    assign accept   = s_tvalid && s_tready;

    // Decode the item
    logic [1:0] req;
    logic       ferr;
    logic       is_tick;
    logic       good_byte;
    logic       rx_drop;     // framing error or timeout: reset the write side

    assign req       = s_tuser[1:0];
    assign ferr      = s_tuser[2];
    assign is_tick   = accept && (req == d54b_pkg::REQ_TICK);
    assign good_byte = accept && (req == d54b_pkg::REQ_BYTE) && !ferr;
    assign rx_drop   = accept && (((req == d54b_pkg::REQ_BYTE) && ferr)
                                  || (req == d54b_pkg::REQ_TIMEOUT));

    // ------------------------------------------------------------------
    // Frame sequencer state
    // ------------------------------------------------------------------
    d54b_pkg::phase_t phase_reg, phase_next;
    logic [9:0]       read_index_reg, read_index_next;
    logic             sync_reg, sync_next;
    logic [7:0]       hold_reg, hold_next;
    d54b_pkg::data_op_t data_op;
    logic             rd_en;
    logic             rd_in_range;
    logic             more_channels;

    assign rd_in_range   = (32'(read_index_reg) < d54b_pkg::STORE_DEPTH);
    assign more_channels = (read_index_reg < channel_count_reg);

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (is_tick)
        begin
            case (phase_reg)
                d54b_pkg::PH_START: phase_next = d54b_pkg::PH_SYNC;
                d54b_pkg::PH_SYNC:  phase_next = d54b_pkg::PH_BYTE;
                d54b_pkg::PH_BYTE:  phase_next = more_channels ? d54b_pkg::PH_SYNC
                                                               : d54b_pkg::PH_EOF;
                d54b_pkg::PH_EOF:   phase_next = d54b_pkg::PH_START;
                default:            phase_next = d54b_pkg::PH_START;
            endcase
        end
    end

    // Phase actions
    always_comb
    begin
        read_index_next = read_index_reg;
        sync_next       = sync_reg;
        hold_next       = hold_reg;
        data_op         = d54b_pkg::DATA_KEEP;
        rd_en           = 1'b0;
        if (is_tick)
        begin
            case (phase_reg)
                d54b_pkg::PH_START:
                begin
                    read_index_next = '0;
                    data_op         = d54b_pkg::DATA_ZERO;
                    sync_next       = 1'b1;
                    hold_next       = sync_ticks_reg;
                end
                d54b_pkg::PH_SYNC:
                begin
                    // fetch the channel byte; past the store end it reads as zero
                    data_op         = rd_in_range ? d54b_pkg::DATA_LOAD : d54b_pkg::DATA_ZERO;
                    rd_en           = rd_in_range;
                    read_index_next = read_index_reg + 10'd1;
                    sync_next       = 1'b0;
                    hold_next       = byte_ticks_reg;
                end
                d54b_pkg::PH_BYTE:
                begin
                    data_op   = d54b_pkg::DATA_ZERO;
                    sync_next = 1'b1;
                    hold_next = more_channels ? sync_ticks_reg : eof_ticks_reg;
                end
                default:
                begin
                    data_op   = d54b_pkg::DATA_ZERO;
                    sync_next = 1'b0;
                    hold_next = start_ticks_reg;
                end
            endcase
        end
    end

    // DMX receive side: write index and ok flag
    logic [d54b_pkg::STORE_AW-1:0] write_index_reg, write_index_next;
    logic                          ok_reg, ok_next;

    always_comb
    begin
        write_index_next = write_index_reg;
        ok_next          = ok_reg;
        if (good_byte)
        begin
            ok_next = 1'b1;
            if (32'(write_index_reg) == d54b_pkg::STORE_DEPTH - 1)
                write_index_next = '0;
            else
                write_index_next = write_index_reg + 1'b1;
        end
        else if (rx_drop)
        begin
            ok_next          = 1'b0;
            write_index_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= d54b_pkg::PH_START;
            read_index_reg  <= '0;
            sync_reg        <= 1'b0;
            hold_reg        <= d54b_pkg::START_TICKS_RST;
            write_index_reg <= '0;
            ok_reg          <= 1'b1;
        end
        else
        begin
            phase_reg       <= phase_next;
            read_index_reg  <= read_index_next;
            sync_reg        <= sync_next;
            hold_reg        <= hold_next;
            write_index_reg <= write_index_next;
            ok_reg          <= ok_next;
        end
    end

    // ------------------------------------------------------------------
    // Channel store: one write port, one registered read port.
    // A byte written by one item is visible to the read of any later item,
    // since a read and a write never come from the same item.
    // ------------------------------------------------------------------
    logic [7:0]                    store_mem [d54b_pkg::STORE_DEPTH];
    logic                          mem_we;
    logic [d54b_pkg::STORE_AW-1:0] mem_waddr;
    logic [7:0]                    mem_wdata;
    logic [7:0]                    mem_rdata_reg;

    assign mem_we    = clearing_reg || good_byte;
    assign mem_waddr = clearing_reg ? clr_cnt_reg : write_index_reg;
    assign mem_wdata = clearing_reg ? 8'd0 : s_tdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_waddr] <= mem_wdata;
    end

    // Read data is held until its item leaves stage 1
    always_ff @(posedge clk)
    begin
        if (rd_en)
            mem_rdata_reg <= store_mem[read_index_reg[d54b_pkg::STORE_AW-1:0]];
    end

    // Clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (32'(clr_cnt_reg) == d54b_pkg::STORE_DEPTH - 1)
                clearing_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: item waits for its store read
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.data_op <= data_op;
            s1_reg.sync    <= sync_next;
            s1_reg.hold    <= hold_next;
            s1_reg.updated <= is_tick;
            s1_reg.ok      <= ok_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register; data_reg is the D54 data register itself
    // ------------------------------------------------------------------
    logic [7:0] data_reg, data_next;
    logic       out_sync_reg;
    logic [7:0] out_hold_reg;
    logic       out_updated_reg;
    logic       out_ok_reg;

    always_comb
    begin
        case (s1_reg.data_op)
            d54b_pkg::DATA_ZERO: data_next = 8'd0;
            d54b_pkg::DATA_LOAD: data_next = mem_rdata_reg;
            default:             data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            data_reg     <= 8'd0;
        end
        else if (s1_move)
        begin
            m_tvalid_reg <= 1'b1;
            data_reg     <= data_next;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_sync_reg    <= s1_reg.sync;
            out_hold_reg    <= s1_reg.hold;
            out_updated_reg <= s1_reg.updated;
            out_ok_reg      <= s1_reg.ok;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0,
                       out_ok_reg,
                       out_updated_reg,
                       out_hold_reg,
                       out_sync_reg ^ sync_active_low_reg,
                       out_sync_reg,
                       data_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_accept_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s_tready)
        else $error("item accepted during store clearing");

    a_no_overwrite_stalled_stage: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |-> !(s1_valid_reg && !s1_adv))
        else $error("accepted item overwrote a stalled stage 1 item");

    a_start_tick_enters_sync: assert property (
        @(posedge clk) disable iff (!rst_n)
        (is_tick && phase_reg == d54b_pkg::PH_START)
            |=> (phase_reg == d54b_pkg::PH_SYNC) && (read_index_reg == 10'd0) && sync_reg)
        else $error("start tick did not open a frame");

    a_read_only_in_sync: assert property (
        @(posedge clk) disable iff (!rst_n)
        rd_en |-> (phase_reg == d54b_pkg::PH_SYNC) && !mem_we)
        else $error("store read outside the sync phase or together with a write");

endmodule

@@ bench/dmx_to_d54_frame_bridge_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the DMX512 to D54 frame bridge: directed table and random traffic.
module dmx_to_d54_frame_bridge_unit_tb;

    // Idle cycles with no item moving on either side before the run is declared hung.
    // Covers the store clearing pass after reset plus the longest gaps and stalls.
    localparam int WATCHDOG_LIMIT = 3000;
    // Margin after the last result is back, before touching registers.
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_ITEMS   = 580;

    // Request code with no meaning to the block, and register slots past the last one
    localparam logic [1:0]                  REQ_UNUSED   = 2'd3;
    localparam logic [d54b_pkg::CFG_AW-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [d54b_pkg::CFG_AW-1:0] CFG_SPARE_HI = 3'd7;

    // One result item, by field
    typedef struct packed {
        logic [7:0] data_out;
        logic       sync_asserted;
        logic       sync_pin;
        logic [7:0] hold_ticks;
        logic       hold_updated;
        logic       dmx_ok;
    } result_t;

    // One row of the directed plan: either a register write or an input item
    typedef struct {
        bit                          is_cfg;
        logic [d54b_pkg::CFG_AW-1:0] addr;
        logic [d54b_pkg::CFG_DW-1:0] wval;
        logic [1:0]                  req;
        logic [7:0]                  rx;
        logic                        fe;
        bit                          pinned;
        result_t                     want;
    } plan_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [d54b_pkg::CFG_AW-1:0]   cfg_addr;
    logic [d54b_pkg::CFG_DW-1:0]   cfg_wdata;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [7:0]                    s_tdata;   // [7:0] rx_byte
    logic [2:0]                    s_tuser;   // [1:0] req_type, [2] framing_error
    logic                          m_tvalid;
    logic                          m_tready;
    logic [23:0]                   m_tdata;   // [7:0] data_out, [8] sync_asserted,
                                              // [9] sync_pin, [17:10] hold_ticks,
                                              // [18] hold_updated, [19] dmx_ok,
                                              // [23:20] zero

    dmx_to_d54_frame_bridge_unit u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // ------------------------------------------------------------------
    // Frame bridge predictor: its own copy of registers and state
    // ------------------------------------------------------------------
    logic [9:0]                    chan_count;
    logic [7:0]                    sync_len;
    logic [7:0]                    byte_len;
    logic [7:0]                    eof_len;
    logic [7:0]                    start_len;
    logic                          active_low;

    d54b_pkg::phase_t              frame_phase;
    logic [9:0]                    rd_ptr;
    logic [d54b_pkg::STORE_AW-1:0] wr_ptr;
    logic [7:0]                    store_img [d54b_pkg::STORE_DEPTH];
    logic [7:0]                    data_q;
    logic                          sync_q;
    logic                          ok_q;
    logic [7:0]                    hold_q;

    // Expected result items, oldest first
    result_t             pending_results[$];

    // Run statistics and traffic shaping knobs
    int                  errors;
    int                  items_accepted;
    int                  results_checked;
    int                  frames_done;
    int                  reg_writes;
    int                  random_items;
    int                  src_gap_pct;
    int                  sink_stall_pct;

    plan_row_t           plan[$];

    // Advance the predictor by one accepted item and return the result it causes.
    function automatic result_t bridge_step(input logic [1:0] req, input logic [7:0] rx,
                                            input logic fe);
        result_t r;
        logic    loaded;
        loaded = 1'b0;
        case (req)
            d54b_pkg::REQ_BYTE:
            begin
                if (fe)
                begin
                    ok_q   = 1'b0;
                    wr_ptr = '0;
                end
                else
                begin
                    store_img[wr_ptr] = rx;
                    if (32'(wr_ptr) == d54b_pkg::STORE_DEPTH - 1)
                        wr_ptr = '0;
                    else
                        wr_ptr = wr_ptr + 1'b1;
                    ok_q = 1'b1;
                end
            end
            d54b_pkg::REQ_TIMEOUT:
            begin
                ok_q   = 1'b0;
                wr_ptr = '0;
            end
            d54b_pkg::REQ_TICK:
            begin
                loaded = 1'b1;
                case (frame_phase)
                    d54b_pkg::PH_START:
                    begin
                        rd_ptr      = '0;
                        data_q      = 8'h00;
                        sync_q      = 1'b1;
                        frame_phase = d54b_pkg::PH_SYNC;
                        hold_q      = sync_len;
                    end
                    d54b_pkg::PH_SYNC:
                    begin
                        sync_q      = 1'b0;
                        // Reads past the end of the store send zero
                        data_q      = (32'(rd_ptr) < d54b_pkg::STORE_DEPTH) ?
                                      store_img[rd_ptr[d54b_pkg::STORE_AW-1:0]] : 8'h00;
                        rd_ptr      = rd_ptr + 10'd1;
                        frame_phase = d54b_pkg::PH_BYTE;
                        hold_q      = byte_len;
                    end
                    d54b_pkg::PH_BYTE:
                    begin
                        data_q = 8'h00;
                        sync_q = 1'b1;
                        if (rd_ptr < chan_count)
                        begin
                            frame_phase = d54b_pkg::PH_SYNC;
                            hold_q      = sync_len;
                        end
                        else
                        begin
                            frame_phase = d54b_pkg::PH_EOF;
                            hold_q      = eof_len;
                        end
                    end
                    default:
                    begin
                        sync_q      = 1'b0;
                        data_q      = 8'h00;
                        frame_phase = d54b_pkg::PH_START;
                        hold_q      = start_len;
                        frames_done++;
                    end
                endcase
            end
            default: ;
        endcase
        r.data_out      = data_q;
        r.sync_asserted = sync_q;
        r.sync_pin      = sync_q ^ active_low;
        r.hold_ticks    = hold_q;
        r.hold_updated  = loaded;
        r.dmx_ok        = ok_q;
        return r;
    endfunction

    // Gap length: usually drawn from the short range, about one time in ten from the long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return int'($urandom_range(8, 40));
        return int'($urandom_range(1, 3));
    endfunction

    // Hold interval for a register write, biased toward the extremes
    function automatic logic [d54b_pkg::CFG_DW-1:0] pick_ticks();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 15)
            return 10'd0;
        if (r < 30)
            return 10'd255;
        if (r < 40)
            return 10'd1;
        return 10'($urandom_range(2, 254));
    endfunction

    function automatic result_t make_result(input logic [7:0] d, input logic s, input logic p,
                                            input logic [7:0] h, input logic u, input logic o);
        result_t r;
        r.data_out      = d;
        r.sync_asserted = s;
        r.sync_pin      = p;
        r.hold_ticks    = h;
        r.hold_updated  = u;
        r.dmx_ok        = o;
        return r;
    endfunction

    function automatic void plan_cfg(input logic [d54b_pkg::CFG_AW-1:0] addr,
                                     input logic [d54b_pkg::CFG_DW-1:0] v);
        plan_row_t row;
        row        = '{default: '0};
        row.is_cfg = 1'b1;
        row.addr   = addr;
        row.wval   = v;
        plan.push_back(row);
    endfunction

    function automatic void plan_item(input logic [1:0] req, input logic [7:0] rx, input logic fe);
        plan_row_t row;
        row     = '{default: '0};
        row.req = req;
        row.rx  = rx;
        row.fe  = fe;
        plan.push_back(row);
    endfunction

    function automatic void plan_pinned(input logic [1:0] req, input logic [7:0] rx,
                                        input logic fe, input result_t want);
        plan_row_t row;
        row        = '{default: '0};
        row.req    = req;
        row.rx     = rx;
        row.fe     = fe;
        row.pinned = 1'b1;
        row.want   = want;
        plan.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Input side: offer one item, hold it until accepted, then predict.
    // Valid stays high into the next item when no gap is drawn, so it is
    // never lowered and raised in the same step.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [1:0] req, input logic [7:0] rx, input logic fe,
                             input bit pinned, input result_t want);
        int      gap;
        result_t predicted;
        gap = ($urandom_range(0, 99) < src_gap_pct) ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        s_tuser  <= {fe, req};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        // Item taken at this edge: advance the predictor in acceptance order
        predicted = bridge_step(req, rx, fe);
        pending_results.push_back(pinned ? want : predicted);
        items_accepted++;
    endtask

    // Drop valid and wait until every expected result is back, then wait
    // SETTLE_CYCLES more so the block is idle for a register write.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; the enable is back low before the task returns.
    task automatic write_reg(input logic [d54b_pkg::CFG_AW-1:0] addr,
                             input logic [d54b_pkg::CFG_DW-1:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= v;
        @(posedge clk);
        case (addr)
            d54b_pkg::CFG_CHANNEL_COUNT:   chan_count = v;
            d54b_pkg::CFG_SYNC_TICKS:      sync_len   = v[7:0];
            d54b_pkg::CFG_BYTE_TICKS:      byte_len   = v[7:0];
            d54b_pkg::CFG_EOF_TICKS:       eof_len    = v[7:0];
            d54b_pkg::CFG_START_TICKS:     start_len  = v[7:0];
            d54b_pkg::CFG_SYNC_ACTIVE_LOW: active_low = v[0];
            default: ;    // out-of-range index: the block ignores it
        endcase
        reg_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Output side: random back-pressure, short stalls mostly, a few long
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 99) < sink_stall_pct)
            begin
                m_tready   <= 1'b0;
                stall_left = pick_gap() - 1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard and watchdog
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] seen);
        if (seen !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h",
                     $time, name, want, seen);
        end
    endtask

    initial
    begin : scoreboard
        result_t want;
        int      idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            // Compare before anything new is queued at this edge
            if (rst_n && m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result item with none expected, actual 0x%06h",
                             $time, m_tdata);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("data_out",      want.data_out,        m_tdata[7:0]);
                    check_field("sync_asserted", 8'(want.sync_asserted), 8'(m_tdata[8]));
                    check_field("sync_pin",      8'(want.sync_pin),      8'(m_tdata[9]));
                    check_field("hold_ticks",    want.hold_ticks,      m_tdata[17:10]);
                    check_field("hold_updated",  8'(want.hold_updated),  8'(m_tdata[18]));
                    check_field("dmx_ok",        8'(want.dmx_ok),        8'(m_tdata[19]));
                    check_field("tdata pad",     8'h00,                {4'h0, m_tdata[23:20]});
                    results_checked++;
                end
            end
            // Reset the watchdog whenever an item moves on either side
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, pending_results.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int          k;
        logic [1:0]  req;
        logic        fe;

        // Drive every input to a known value and hold reset
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;

        errors          = 0;
        items_accepted  = 0;
        results_checked = 0;
        frames_done     = 0;
        reg_writes      = 0;
        random_items    = 0;
        src_gap_pct     = 20;
        sink_stall_pct  = 20;

        // Predictor starts from the reset state of the block
        chan_count  = d54b_pkg::CHANNEL_COUNT_RST;
        sync_len    = d54b_pkg::SYNC_TICKS_RST;
        byte_len    = d54b_pkg::BYTE_TICKS_RST;
        eof_len     = d54b_pkg::EOF_TICKS_RST;
        start_len   = d54b_pkg::START_TICKS_RST;
        active_low  = 1'b0;
        frame_phase = d54b_pkg::PH_START;
        rd_ptr      = '0;
        wr_ptr      = '0;
        foreach (store_img[i])
            store_img[i] = 8'h00;
        data_q = 8'h00;
        sync_q = 1'b0;
        ok_q   = 1'b1;
        hold_q = d54b_pkg::START_TICKS_RST;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // --- Directed plan, part one: reset register values ---
        // Timeout clears the ok flag; good bytes set it; a framing error clears it
        plan_pinned(d54b_pkg::REQ_TIMEOUT, 8'h00, 1'b0,
                    make_result(8'h00, 1'b0, 1'b0, 8'd10, 1'b0, 1'b0));
        plan_pinned(d54b_pkg::REQ_BYTE,    8'hFF, 1'b0,
                    make_result(8'h00, 1'b0, 1'b0, 8'd10, 1'b0, 1'b1));
        plan_pinned(d54b_pkg::REQ_BYTE,    8'h00, 1'b0,
                    make_result(8'h00, 1'b0, 1'b0, 8'd10, 1'b0, 1'b1));
        plan_pinned(d54b_pkg::REQ_BYTE,    8'hA5, 1'b1,
                    make_result(8'h00, 1'b0, 1'b0, 8'd10, 1'b0, 1'b0));
        // Store restarts at entry zero after the framing error
        plan_item(d54b_pkg::REQ_BYTE, 8'h5A, 1'b0);
        plan_item(d54b_pkg::REQ_BYTE, 8'h81, 1'b0);
        // Unused request code leaves everything as it was
        plan_pinned(REQ_UNUSED,            8'hFF, 1'b1,
                    make_result(8'h00, 1'b0, 1'b0, 8'd10, 1'b0, 1'b1));
        // Frame start: sync on with the reset sync hold
        plan_pinned(d54b_pkg::REQ_TICK,    8'h00, 1'b0,
                    make_result(8'h00, 1'b1, 1'b1, 8'd1, 1'b1, 1'b1));
        plan_item(d54b_pkg::REQ_TICK, 8'h00, 1'b0);
        plan_pinned(d54b_pkg::REQ_TICK,    8'h00, 1'b0,
                    make_result(8'h00, 1'b1, 1'b1, 8'd1, 1'b1, 1'b1));
        plan_item(d54b_pkg::REQ_TICK, 8'h00, 1'b0);
        plan_item(d54b_pkg::REQ_TIMEOUT, 8'h55, 1'b1);

        // --- Part two: zero channel count, zero and full holds, inverted sync ---
        plan_cfg(d54b_pkg::CFG_CHANNEL_COUNT,   10'd0);
        plan_cfg(d54b_pkg::CFG_SYNC_TICKS,      10'd0);
        plan_cfg(d54b_pkg::CFG_BYTE_TICKS,      10'd255);
        plan_cfg(d54b_pkg::CFG_EOF_TICKS,       10'd0);
        plan_cfg(d54b_pkg::CFG_START_TICKS,     10'd255);
        plan_cfg(d54b_pkg::CFG_SYNC_ACTIVE_LOW, 10'd1);
        plan_cfg(CFG_SPARE_LO,                  10'h3FF);
        plan_cfg(CFG_SPARE_HI,                  10'h000);
        repeat (6) plan_item(d54b_pkg::REQ_TICK, 8'h00, 1'b0);

        // --- Part three: widest channel count, other extremes swapped ---
        plan_cfg(d54b_pkg::CFG_CHANNEL_COUNT,   10'h3FF);
        plan_cfg(d54b_pkg::CFG_SYNC_TICKS,      10'd255);
        plan_cfg(d54b_pkg::CFG_BYTE_TICKS,      10'd1);
        plan_cfg(d54b_pkg::CFG_EOF_TICKS,       10'd255);
        plan_cfg(d54b_pkg::CFG_START_TICKS,     10'd1);
        plan_cfg(d54b_pkg::CFG_SYNC_ACTIVE_LOW, 10'd0);
        plan_item(d54b_pkg::REQ_BYTE, 8'h3C, 1'b0);
        repeat (4) plan_item(d54b_pkg::REQ_TICK, 8'hC3, 1'b1);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                settle();
                write_reg(plan[i].addr, plan[i].wval);
            end
            else
                send_item(plan[i].req, plan[i].rx, plan[i].fe, plan[i].pinned, plan[i].want);
        end

        // --- Random phases: fresh registers and traffic shape each time ---
        while (random_items < RANDOM_ITEMS)
        begin
            settle();
            // Some phases run with no idling at all on one side or both
            src_gap_pct    = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(5, 50));
            sink_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(5, 50));
            k = int'($urandom_range(0, 99));
            write_reg(d54b_pkg::CFG_CHANNEL_COUNT, (k < 10) ? 10'd0 : (k < 20) ? 10'd1 :
                                                   10'($urandom_range(2, 16)));
            write_reg(d54b_pkg::CFG_SYNC_TICKS,      pick_ticks());
            write_reg(d54b_pkg::CFG_BYTE_TICKS,      pick_ticks());
            write_reg(d54b_pkg::CFG_EOF_TICKS,       pick_ticks());
            write_reg(d54b_pkg::CFG_START_TICKS,     pick_ticks());
            write_reg(d54b_pkg::CFG_SYNC_ACTIVE_LOW, 10'($urandom_range(0, 1)));

            // Often open with a well-formed packet: break, then a burst of good bytes
            if ($urandom_range(0, 1) == 1)
            begin
                send_item(d54b_pkg::REQ_TIMEOUT, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'b0, '0);
                random_items++;
                repeat ($urandom_range(1, 20))
                begin
                    send_item(d54b_pkg::REQ_BYTE, 8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
                    random_items++;
                end
            end

            // Then a mix dominated by ticks and good bytes
            repeat ($urandom_range(30, 60))
            begin
                k   = int'($urandom_range(0, 99));
                req = (k < 45) ? d54b_pkg::REQ_TICK : (k < 86) ? d54b_pkg::REQ_BYTE :
                      (k < 93) ? d54b_pkg::REQ_TIMEOUT : REQ_UNUSED;
                fe  = (req != d54b_pkg::REQ_BYTE) ? 1'($urandom_range(0, 1)) : (k >= 80);
                send_item(req, 8'($urandom_range(0, 255)), fe, 1'b0, '0);
                if (req != REQ_UNUSED)
                    random_items++;
            end
        end

        // Drain: every expected result back, plus the pipeline latency
        settle();

        $display("Run covered %0d input items (%0d in random phases) and %0d result items,",
                 items_accepted, random_items, results_checked);
        $display("with %0d frames sent end to end and %0d register writes; %0d mismatches.",
                 frames_done, reg_writes, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
